// ===== hdl/lgpm_pkg.sv =====
// shared types, register map and constants of the gradient pixel modulator
package lgpm_pkg;

  localparam int MAX_SIDE_DEF = 4096;
  localparam int CHANNELS     = 4;
  localparam int PADDR_W      = 6;
  localparam int PDATA_W      = 64;
  localparam int SIDE_W       = 13;
  localparam int POS_W        = 32;
  localparam int GAIN_W       = 16;
  localparam int PIX_W        = 8;
  localparam int REG_IDX_W    = 3;

  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_STEP_COL     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_STEP_ROW     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COLOR_MIN    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_COLOR_MAX    = 3'd5;

  localparam logic [SIDE_W-1:0]         SIDE_RESET      = 13'd256;
  localparam logic [CHANNELS*GAIN_W-1:0] COLOR_MAX_RESET = 64'h8000_8000_8000_8000;

  localparam logic [POS_W-1:0]  ONE_Q24 = 32'h0100_0000;
  localparam logic [GAIN_W-1:0] ONE_Q15 = 16'h8000;

  typedef struct packed {
    logic [SIDE_W-1:0]          image_width;
    logic [SIDE_W-1:0]          image_height;
    logic [POS_W-1:0]           step_per_column;
    logic [POS_W-1:0]           step_per_row;
    logic [CHANNELS*GAIN_W-1:0] color_min;
    logic [CHANNELS*GAIN_W-1:0] color_max;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic load_out;
  } cmd_t;

endpackage

// ===== hdl/lgpm_regs.sv =====
// configuration register file behind the apb port
module lgpm_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lgpm_pkg::PADDR_W-1:0]  paddr,
  input  logic [lgpm_pkg::PDATA_W-1:0]  pwdata,
  output logic [lgpm_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output lgpm_pkg::cfg_t                cfg
);

  logic [lgpm_pkg::REG_IDX_W-1:0] idx;
  logic                           wr;

  assign idx    = paddr[lgpm_pkg::PADDR_W-1:3];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width     <= lgpm_pkg::SIDE_RESET;
      cfg.image_height    <= lgpm_pkg::SIDE_RESET;
      cfg.step_per_column <= '0;
      cfg.step_per_row    <= '0;
      cfg.color_min       <= '0;
      cfg.color_max       <= lgpm_pkg::COLOR_MAX_RESET;
    end else if (wr) begin
      case (idx)
        lgpm_pkg::REG_IMAGE_WIDTH:  cfg.image_width     <= pwdata[lgpm_pkg::SIDE_W-1:0];
        lgpm_pkg::REG_IMAGE_HEIGHT: cfg.image_height    <= pwdata[lgpm_pkg::SIDE_W-1:0];
        lgpm_pkg::REG_STEP_COL:     cfg.step_per_column <= pwdata[lgpm_pkg::POS_W-1:0];
        lgpm_pkg::REG_STEP_ROW:     cfg.step_per_row    <= pwdata[lgpm_pkg::POS_W-1:0];
        lgpm_pkg::REG_COLOR_MIN:    cfg.color_min       <= pwdata;
        lgpm_pkg::REG_COLOR_MAX:    cfg.color_max       <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      lgpm_pkg::REG_IMAGE_WIDTH:  prdata = lgpm_pkg::PDATA_W'(cfg.image_width);
      lgpm_pkg::REG_IMAGE_HEIGHT: prdata = lgpm_pkg::PDATA_W'(cfg.image_height);
      lgpm_pkg::REG_STEP_COL:     prdata = lgpm_pkg::PDATA_W'(cfg.step_per_column);
      lgpm_pkg::REG_STEP_ROW:     prdata = lgpm_pkg::PDATA_W'(cfg.step_per_row);
      lgpm_pkg::REG_COLOR_MIN:    prdata = cfg.color_min;
      lgpm_pkg::REG_COLOR_MAX:    prdata = cfg.color_max;
      default:                    prdata = '0;
    endcase
  end

endmodule

// ===== hdl/lgpm_ctrl.sv =====
// controller state machine: input handshake, sequencing and output valid
module lgpm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output lgpm_pkg::cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL1 = 2'd1;
  localparam logic [1:0] ST_MUL2 = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign in_ready     = (state == ST_IDLE);
  assign out_free     = !out_valid || out_ready;
  assign cmd.capture  = in_valid && in_ready;
  assign cmd.load_out = (state == ST_DONE) && out_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (cmd.capture) state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/lgpm_dp.sv =====
// datapath: raster counters, gradient position, gain lerp and channel scaling
module lgpm_dp #(
  parameter int MAX_SIDE = lgpm_pkg::MAX_SIDE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lgpm_pkg::cfg_t              cfg,
  input  lgpm_pkg::cmd_t              cmd,
  input  logic [lgpm_pkg::PIX_W-1:0]  in_ch0,
  input  logic [lgpm_pkg::PIX_W-1:0]  in_ch1,
  input  logic [lgpm_pkg::PIX_W-1:0]  in_ch2,
  input  logic [lgpm_pkg::PIX_W-1:0]  in_ch3,
  output logic [lgpm_pkg::PIX_W-1:0]  out_ch0,
  output logic [lgpm_pkg::PIX_W-1:0]  out_ch1,
  output logic [lgpm_pkg::PIX_W-1:0]  out_ch2,
  output logic [lgpm_pkg::PIX_W-1:0]  out_ch3,
  output logic                        frame_end
);

  localparam int CNT_W  = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
  localparam int CMP_W  = (CNT_W + 1 > lgpm_pkg::SIDE_W) ? CNT_W + 1 : lgpm_pkg::SIDE_W;
  localparam int CH     = lgpm_pkg::CHANNELS;
  localparam int GW     = lgpm_pkg::GAIN_W;
  localparam int PW     = lgpm_pkg::PIX_W;
  localparam int PROD_W = 2 * GW;
  localparam int V_W    = PW + GW;

  logic [CNT_W-1:0]              column_count;
  logic [CNT_W-1:0]              row_count;
  logic [lgpm_pkg::POS_W-1:0]    row_start_position;
  logic [lgpm_pkg::POS_W-1:0]    pixel_position;
  logic [GW-1:0]                 t_q;
  logic [CH-1:0][PW-1:0]         ch_q;
  logic                          fe_q;
  logic [CH-1:0][PROD_W-1:0]     p_min;
  logic [CH-1:0][PROD_W-1:0]     p_max;
  logic [CH-1:0][V_W-1:0]        v_q;
  logic [CH-1:0][PW-1:0]         out_q;

  logic [CMP_W-1:0]              w_lim;
  logic [CMP_W-1:0]              h_lim;
  logic                          last_col;
  logic                          last_row;
  logic [GW-1:0]                 t_now;
  logic [lgpm_pkg::POS_W-1:0]    row_start_next;

  // clamp the configured sides to 1..MAX_SIDE
  always_comb begin
    if (cfg.image_width == '0) begin
      w_lim = CMP_W'(1);
    end else if (CMP_W'(cfg.image_width) > CMP_W'(MAX_SIDE)) begin
      w_lim = CMP_W'(MAX_SIDE);
    end else begin
      w_lim = CMP_W'(cfg.image_width);
    end
    if (cfg.image_height == '0) begin
      h_lim = CMP_W'(1);
    end else if (CMP_W'(cfg.image_height) > CMP_W'(MAX_SIDE)) begin
      h_lim = CMP_W'(MAX_SIDE);
    end else begin
      h_lim = CMP_W'(cfg.image_height);
    end
  end

  assign last_col       = CMP_W'(column_count) >= (w_lim - CMP_W'(1));
  assign last_row       = CMP_W'(row_count) >= (h_lim - CMP_W'(1));
  assign row_start_next = row_start_position + cfg.step_per_row;

  // position clamped to [0,1] as q1.15 weight
  always_comb begin
    if (pixel_position[lgpm_pkg::POS_W-1]) begin
      t_now = '0;
    end else if (pixel_position >= lgpm_pkg::ONE_Q24) begin
      t_now = lgpm_pkg::ONE_Q15;
    end else begin
      t_now = {1'b0, pixel_position[23:9]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count       <= '0;
      row_count          <= '0;
      row_start_position <= '0;
      pixel_position     <= '0;
    end else if (cmd.capture) begin
      if (!last_col) begin
        column_count   <= column_count + CNT_W'(1);
        pixel_position <= pixel_position + cfg.step_per_column;
      end else if (!last_row) begin
        column_count       <= '0;
        row_count          <= row_count + CNT_W'(1);
        row_start_position <= row_start_next;
        pixel_position     <= row_start_next;
      end else begin
        column_count       <= '0;
        row_count          <= '0;
        row_start_position <= '0;
        pixel_position     <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      t_q     <= t_now;
      ch_q[0] <= in_ch0;
      ch_q[1] <= in_ch1;
      ch_q[2] <= in_ch2;
      ch_q[3] <= in_ch3;
      fe_q    <= last_col && last_row;
    end
  end

  // stage one: lerp products, stage two: channel times gain
  always_ff @(posedge clk) begin
    for (int k = 0; k < CH; k++) begin
      p_min[k] <= cfg.color_min[k*GW +: GW] * (lgpm_pkg::ONE_Q15 - t_q);
      p_max[k] <= cfg.color_max[k*GW +: GW] * t_q;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < CH; k++) begin
      v_q[k] <= V_W'(ch_q[k]) * V_W'(((p_min[k] + p_max[k]) >> 15) & 32'h0000_FFFF);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      for (int k = 0; k < CH; k++) begin
        out_q[k] <= v_q[k][V_W-1] ? {PW{1'b1}} : v_q[k][V_W-2:V_W-1-PW];
      end
      frame_end <= fe_q;
    end
  end

  assign out_ch0 = out_q[0];
  assign out_ch1 = out_q[1];
  assign out_ch2 = out_q[2];
  assign out_ch3 = out_q[3];

endmodule

// ===== hdl/linear_gradient_pixel_modulate.sv =====
// top level of the linear gradient pixel modulator
//
//   channel  handshake                          payload
//   in       in_valid / in_ready                in_ch0..in_ch3
//   out      out_valid / out_ready              out_ch0..out_ch3, frame_end
//   cfg      psel, penable, pwrite, pready      paddr, pwdata, prdata
//
// one pixel goes through capture, lerp multiply, channel multiply and
// output load; the two multiply stages are registered
// a stalled output holds the finished pixel while the next one is taken in
// and worked; that one waits in the last step until the output frees
// rst is synchronous and returns counters, positions and configuration registers to defaults
module linear_gradient_pixel_modulate #(
  parameter int MAX_SIDE = lgpm_pkg::MAX_SIDE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lgpm_pkg::PADDR_W-1:0]  paddr,
  input  logic [lgpm_pkg::PDATA_W-1:0]  pwdata,
  output logic [lgpm_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lgpm_pkg::PIX_W-1:0]    in_ch0,
  input  logic [lgpm_pkg::PIX_W-1:0]    in_ch1,
  input  logic [lgpm_pkg::PIX_W-1:0]    in_ch2,
  input  logic [lgpm_pkg::PIX_W-1:0]    in_ch3,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lgpm_pkg::PIX_W-1:0]    out_ch0,
  output logic [lgpm_pkg::PIX_W-1:0]    out_ch1,
  output logic [lgpm_pkg::PIX_W-1:0]    out_ch2,
  output logic [lgpm_pkg::PIX_W-1:0]    out_ch3,
  output logic                          frame_end
);

  lgpm_pkg::cfg_t cfg;
  lgpm_pkg::cmd_t cmd;

  lgpm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lgpm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lgpm_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .in_ch0    (in_ch0),
    .in_ch1    (in_ch1),
    .in_ch2    (in_ch2),
    .in_ch3    (in_ch3),
    .out_ch0   (out_ch0),
    .out_ch1   (out_ch1),
    .out_ch2   (out_ch2),
    .out_ch3   (out_ch3),
    .frame_end (frame_end)
  );

endmodule

// ===== hdl/lgpm_checker.sv =====
// port-level checker of the gradient pixel modulator and its bind
module lgpm_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [lgpm_pkg::PIX_W-1:0]  out_ch0,
  input  logic [lgpm_pkg::PIX_W-1:0]  out_ch1,
  input  logic [lgpm_pkg::PIX_W-1:0]  out_ch2,
  input  logic [lgpm_pkg::PIX_W-1:0]  out_ch3,
  input  logic                        frame_end
);

  // a transaction keeps the block busy for the three working steps
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("input taken while a pixel is still in work");

  // a new result is loaded as the block goes back to taking input
  a_rise_with_ready: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result appeared without the controller returning to idle");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid survived reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_ch0) && $stable(out_ch1)
      && $stable(out_ch2) && $stable(out_ch3) && $stable(frame_end))
    else $error("stalled output transaction changed");

endmodule

bind linear_gradient_pixel_modulate lgpm_checker u_lgpm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_ch0   (out_ch0),
  .out_ch1   (out_ch1),
  .out_ch2   (out_ch2),
  .out_ch3   (out_ch3),
  .frame_end (frame_end)
);

// ===== verif/linear_gradient_pixel_modulate_tb.sv =====
// self-checking testbench for the linear gradient pixel modulator
module linear_gradient_pixel_modulate_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [lgpm_pkg::REG_IDX_W-1:0] REG_SPARE = 3'd6;

  typedef logic [lgpm_pkg::CHANNELS-1:0][lgpm_pkg::PIX_W-1:0] pixel_t;

  typedef struct packed {
    logic [lgpm_pkg::CHANNELS-1:0][lgpm_pkg::PIX_W-1:0] ch;
    logic                                               frame_end;
  } result_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [lgpm_pkg::PADDR_W-1:0] paddr = '0;
  logic [lgpm_pkg::PDATA_W-1:0] pwdata = '0;
  logic [lgpm_pkg::PDATA_W-1:0] prdata;
  logic                         pready;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [lgpm_pkg::PIX_W-1:0]   in_ch0 = '0;
  logic [lgpm_pkg::PIX_W-1:0]   in_ch1 = '0;
  logic [lgpm_pkg::PIX_W-1:0]   in_ch2 = '0;
  logic [lgpm_pkg::PIX_W-1:0]   in_ch3 = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [lgpm_pkg::PIX_W-1:0]   out_ch0;
  logic [lgpm_pkg::PIX_W-1:0]   out_ch1;
  logic [lgpm_pkg::PIX_W-1:0]   out_ch2;
  logic [lgpm_pkg::PIX_W-1:0]   out_ch3;
  logic                         frame_end;

  lgpm_pkg::cfg_t shadow_cfg = '{
    image_width:     lgpm_pkg::SIDE_RESET,
    image_height:    lgpm_pkg::SIDE_RESET,
    step_per_column: '0,
    step_per_row:    '0,
    color_min:       '0,
    color_max:       lgpm_pkg::COLOR_MAX_RESET
  };
  logic [11:0]                col_idx = '0;
  logic [11:0]                row_idx = '0;
  logic [lgpm_pkg::POS_W-1:0] row_base_pos = '0;
  logic [lgpm_pkg::POS_W-1:0] cur_pos = '0;

  result_t     expected_pixels[$];
  result_t     got_px;
  result_t     want_px;
  int unsigned err_count = 0;
  bit          idle_on = 1'b1;
  int unsigned stall_cycles = 0;

  linear_gradient_pixel_modulate u_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_ch0    (in_ch0),
    .in_ch1    (in_ch1),
    .in_ch2    (in_ch2),
    .in_ch3    (in_ch3),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_ch0   (out_ch0),
    .out_ch1   (out_ch1),
    .out_ch2   (out_ch2),
    .out_ch3   (out_ch3),
    .frame_end (frame_end)
  );

  always #1 clk = ~clk;

  function automatic logic [lgpm_pkg::SIDE_W-1:0] eff_side(
      input logic [lgpm_pkg::SIDE_W-1:0] v);
    if (v == '0) return lgpm_pkg::SIDE_W'(1);
    if (v > lgpm_pkg::SIDE_W'(lgpm_pkg::MAX_SIDE_DEF))
      return lgpm_pkg::SIDE_W'(lgpm_pkg::MAX_SIDE_DEF);
    return v;
  endfunction

  function automatic logic [lgpm_pkg::SIDE_W-1:0] pick_side();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return lgpm_pkg::SIDE_W'($urandom_range(lgpm_pkg::MAX_SIDE_DEF + 1, 8191));
      2: return lgpm_pkg::SIDE_W'($urandom);
      default: return lgpm_pkg::SIDE_W'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic [lgpm_pkg::PDATA_W-1:0] pick_gains();
    case ($urandom_range(0, 3))
      0: return {$urandom, $urandom};
      1: return lgpm_pkg::COLOR_MAX_RESET;
      default: return {$urandom, $urandom} & 64'h9FFF_9FFF_9FFF_9FFF;
    endcase
  endfunction

  task automatic predict_modulated_pixel(input pixel_t px);
    result_t                     r;
    logic [lgpm_pkg::GAIN_W-1:0] t;
    logic [lgpm_pkg::SIDE_W-1:0] w;
    logic [lgpm_pkg::SIDE_W-1:0] h;
    logic                        last_col;
    logic                        last_row;
    longint unsigned             wt;
    longint unsigned             cmin;
    longint unsigned             cmax;
    longint unsigned             gain;
    longint unsigned             prod;
    if (cur_pos[lgpm_pkg::POS_W-1]) t = '0;
    else if (cur_pos >= lgpm_pkg::ONE_Q24) t = lgpm_pkg::ONE_Q15;
    else t = lgpm_pkg::GAIN_W'(cur_pos >> 9);
    w = eff_side(shadow_cfg.image_width);
    h = eff_side(shadow_cfg.image_height);
    last_col = {1'b0, col_idx} >= w - lgpm_pkg::SIDE_W'(1);
    last_row = {1'b0, row_idx} >= h - lgpm_pkg::SIDE_W'(1);
    wt = t;
    for (int k = 0; k < lgpm_pkg::CHANNELS; k++) begin
      cmin = shadow_cfg.color_min[k*lgpm_pkg::GAIN_W +: lgpm_pkg::GAIN_W];
      cmax = shadow_cfg.color_max[k*lgpm_pkg::GAIN_W +: lgpm_pkg::GAIN_W];
      gain = (cmin * (64'd32768 - wt) + cmax * wt) >> 15;
      prod = (longint'(px[k]) * gain) >> 15;
      r.ch[k] = (prod > 255) ? 8'hFF : 8'(prod);
    end
    r.frame_end = last_col && last_row;
    expected_pixels.push_back(r);
    if (!last_col) begin
      col_idx += 12'd1;
      cur_pos += shadow_cfg.step_per_column;
    end else if (!last_row) begin
      col_idx = '0;
      row_idx += 12'd1;
      row_base_pos += shadow_cfg.step_per_row;
      cur_pos = row_base_pos;
    end else begin
      col_idx = '0;
      row_idx = '0;
      row_base_pos = '0;
      cur_pos = '0;
    end
  endtask

  task automatic send_pixel(input pixel_t px);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_ch3, in_ch2, in_ch1, in_ch0} <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_modulated_pixel(px);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [lgpm_pkg::REG_IDX_W-1:0] idx,
                            input logic [lgpm_pkg::PDATA_W-1:0] wdata,
                            output logic [lgpm_pkg::PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 3'b000};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (wr) begin
      case (idx)
        lgpm_pkg::REG_IMAGE_WIDTH:
          shadow_cfg.image_width = wdata[lgpm_pkg::SIDE_W-1:0];
        lgpm_pkg::REG_IMAGE_HEIGHT:
          shadow_cfg.image_height = wdata[lgpm_pkg::SIDE_W-1:0];
        lgpm_pkg::REG_STEP_COL:
          shadow_cfg.step_per_column = wdata[lgpm_pkg::POS_W-1:0];
        lgpm_pkg::REG_STEP_ROW:
          shadow_cfg.step_per_row = wdata[lgpm_pkg::POS_W-1:0];
        lgpm_pkg::REG_COLOR_MIN: shadow_cfg.color_min = wdata;
        lgpm_pkg::REG_COLOR_MAX: shadow_cfg.color_max = wdata;
        default: ;
      endcase
    end
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [lgpm_pkg::REG_IDX_W-1:0] idx,
                           input logic [lgpm_pkg::PDATA_W-1:0] value);
    logic [lgpm_pkg::PDATA_W-1:0] rd_ignored;
    apb_access(1'b1, idx, value, rd_ignored);
  endtask

  task automatic check_register(input logic [lgpm_pkg::REG_IDX_W-1:0] idx);
    logic [lgpm_pkg::PDATA_W-1:0] want;
    logic [lgpm_pkg::PDATA_W-1:0] got;
    case (idx)
      lgpm_pkg::REG_IMAGE_WIDTH:  want = lgpm_pkg::PDATA_W'(shadow_cfg.image_width);
      lgpm_pkg::REG_IMAGE_HEIGHT: want = lgpm_pkg::PDATA_W'(shadow_cfg.image_height);
      lgpm_pkg::REG_STEP_COL:     want = lgpm_pkg::PDATA_W'(shadow_cfg.step_per_column);
      lgpm_pkg::REG_STEP_ROW:     want = lgpm_pkg::PDATA_W'(shadow_cfg.step_per_row);
      lgpm_pkg::REG_COLOR_MIN:    want = shadow_cfg.color_min;
      lgpm_pkg::REG_COLOR_MAX:    want = shadow_cfg.color_max;
      default:                    want = '0;
    endcase
    apb_access(1'b0, idx, '0, got);
    if (got !== want) begin
      err_count++;
      $display("%0t: register %0d read expected %h actual %h", $time, idx, want, got);
    end
  endtask

  task automatic test_reset_defaults();
    for (int idx = lgpm_pkg::REG_IMAGE_WIDTH; idx <= lgpm_pkg::REG_COLOR_MAX; idx++)
      check_register(lgpm_pkg::REG_IDX_W'(idx));
    send_pixel('0);
    send_pixel('1);
  endtask

  task automatic test_register_access();
    wait_idle();
    for (int idx = lgpm_pkg::REG_IMAGE_WIDTH; idx <= lgpm_pkg::REG_COLOR_MAX; idx++) begin
      write_reg(lgpm_pkg::REG_IDX_W'(idx), '1);
      check_register(lgpm_pkg::REG_IDX_W'(idx));
    end
    for (int idx = lgpm_pkg::REG_IMAGE_WIDTH; idx <= lgpm_pkg::REG_COLOR_MAX; idx++) begin
      write_reg(lgpm_pkg::REG_IDX_W'(idx), 64'hA5A5_5A5A_C3C3_3C3C);
      check_register(lgpm_pkg::REG_IDX_W'(idx));
    end
    // unmapped index must leave every register alone
    write_reg(REG_SPARE, '0);
    for (int idx = lgpm_pkg::REG_IMAGE_WIDTH; idx <= lgpm_pkg::REG_COLOR_MAX; idx++)
      check_register(lgpm_pkg::REG_IDX_W'(idx));
  endtask

  task automatic test_gradient_clamp();
    pixel_t samples[10] = '{
      32'hFF00_80FF, 32'h00FF_FF01, 32'hFFFF_FFFF, 32'h8040_2010, 32'hFFFF_FFFF,
      32'h0000_0000, 32'h7F80_FE01, 32'hFFFF_FFFF, 32'hFF01_80C0, 32'hFFFF_FFFF
    };
    wait_idle();
    // half step per column, minus one per row: negative, mid and saturated weights
    write_reg(lgpm_pkg::REG_IMAGE_WIDTH, 64'd4);
    write_reg(lgpm_pkg::REG_IMAGE_HEIGHT, 64'd2);
    write_reg(lgpm_pkg::REG_STEP_COL, 64'h0080_0000);
    write_reg(lgpm_pkg::REG_STEP_ROW, 64'hFF00_0000);
    write_reg(lgpm_pkg::REG_COLOR_MIN, 64'h0000_FFFF_8000_0001);
    write_reg(lgpm_pkg::REG_COLOR_MAX, 64'hFFFF_0000_8000_7FFF);
    foreach (samples[i]) send_pixel(samples[i]);
  endtask

  task automatic test_degenerate_sizes();
    wait_idle();
    write_reg(lgpm_pkg::REG_IMAGE_WIDTH, '0);
    write_reg(lgpm_pkg::REG_IMAGE_HEIGHT, '0);
    repeat (2) send_pixel(pixel_t'($urandom));
    wait_idle();
    // oversized sides clamp, huge step wraps the position
    write_reg(lgpm_pkg::REG_IMAGE_WIDTH, 64'h1FFF);
    write_reg(lgpm_pkg::REG_IMAGE_HEIGHT, 64'h1FFF);
    write_reg(lgpm_pkg::REG_STEP_COL, 64'h7FFF_FFFF);
    repeat (2) send_pixel(pixel_t'($urandom));
    wait_idle();
    write_reg(lgpm_pkg::REG_IMAGE_WIDTH, 64'd6);
    write_reg(lgpm_pkg::REG_IMAGE_HEIGHT, 64'd3);
    write_reg(lgpm_pkg::REG_STEP_COL, 64'(lgpm_pkg::ONE_Q24 >> 4));
    write_reg(lgpm_pkg::REG_STEP_ROW, 64'(lgpm_pkg::ONE_Q24 >> 1));
    repeat (3) send_pixel(pixel_t'($urandom));
    wait_idle();
    // shrink width under the column counter and change step mid-frame
    write_reg(lgpm_pkg::REG_IMAGE_WIDTH, 64'd2);
    write_reg(lgpm_pkg::REG_STEP_COL, 64'(-(lgpm_pkg::ONE_Q24 >> 3)));
    repeat (2) send_pixel(pixel_t'($urandom));
    wait_idle();
    write_reg(lgpm_pkg::REG_IMAGE_HEIGHT, 64'd1);
    repeat (2) send_pixel(pixel_t'($urandom));
  endtask

  task automatic test_output_backpressure();
    wait_idle();
    idle_on = 1'b0;
    write_reg(lgpm_pkg::REG_IMAGE_WIDTH, 64'd7);
    write_reg(lgpm_pkg::REG_IMAGE_HEIGHT, 64'd4);
    write_reg(lgpm_pkg::REG_STEP_COL, 64'(lgpm_pkg::ONE_Q24 >> 3));
    write_reg(lgpm_pkg::REG_STEP_ROW, 64'(lgpm_pkg::ONE_Q24 >> 2));
    stall_cycles = 150;
    repeat (40) send_pixel(pixel_t'($urandom));
  endtask

  task automatic test_random_frames(input int unsigned target, input bit with_idle);
    int unsigned                  done_cnt;
    int unsigned                  burst;
    logic [lgpm_pkg::POS_W-1:0]   step;
    logic [lgpm_pkg::PDATA_W-1:0] value;
    done_cnt = 0;
    while (done_cnt < target) begin
      wait_idle();
      idle_on = with_idle && ($urandom_range(0, 3) != 0);
      for (int idx = lgpm_pkg::REG_IMAGE_WIDTH; idx <= REG_SPARE; idx++) begin
        if ($urandom_range(0, 1) == 1) begin
          case (lgpm_pkg::REG_IDX_W'(idx))
            lgpm_pkg::REG_IMAGE_WIDTH, lgpm_pkg::REG_IMAGE_HEIGHT:
              value = lgpm_pkg::PDATA_W'(pick_side());
            lgpm_pkg::REG_STEP_COL, lgpm_pkg::REG_STEP_ROW: begin
              step = lgpm_pkg::POS_W'($urandom_range(0, lgpm_pkg::ONE_Q24 >> 2));
              if ($urandom_range(0, 3) == 0) step = $urandom;
              else if ($urandom_range(0, 1) == 1) step = -step;
              value = {$urandom, step};
            end
            lgpm_pkg::REG_COLOR_MIN, lgpm_pkg::REG_COLOR_MAX: value = pick_gains();
            default: value = {$urandom, $urandom};
          endcase
          write_reg(lgpm_pkg::REG_IDX_W'(idx), value);
        end
      end
      burst = $urandom_range(10, 90);
      repeat (burst) send_pixel(pixel_t'($urandom));
      done_cnt += burst;
    end
  endtask

  initial begin : sink_pacing
    int unsigned n;
    forever begin
      @(posedge clk);
      if (stall_cycles != 0) begin
        out_ready <= 1'b0;
        for (n = 0; n < stall_cycles; n++) @(posedge clk);
        stall_cycles = 0;
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 7);
        repeat (n) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_px = {out_ch3, out_ch2, out_ch1, out_ch0, frame_end};
      if (expected_pixels.size() == 0) begin
        err_count++;
        $display("%0t: output transaction expected none actual %h", $time, got_px);
      end else begin
        want_px = expected_pixels.pop_front();
        for (int k = 0; k < lgpm_pkg::CHANNELS; k++) begin
          if (got_px.ch[k] !== want_px.ch[k]) begin
            err_count++;
            $display("%0t: out_ch%0d expected %0d actual %0d", $time, k,
                     want_px.ch[k], got_px.ch[k]);
          end
        end
        if (got_px.frame_end !== want_px.frame_end) begin
          err_count++;
          $display("%0t: frame_end expected %0b actual %0b", $time,
                   want_px.frame_end, got_px.frame_end);
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_register_access();
    test_gradient_clamp();
    test_degenerate_sizes();
    test_output_backpressure();
    test_random_frames(1350, 1'b1);
    test_random_frames(130, 1'b0);
    wait_idle();
    repeat (12) @(posedge clk);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
